// ----- hw/rtl/itrd_pkg.sv -----
// Shared widths, command/status types and digit encoding for the radix converter.
`default_nettype none
package itrd_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int VALUE_W     = 31;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int IDX_W       = $clog2(VALUE_BITS);
    localparam int BIT_W       = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);

    localparam logic [DIGIT_W-1:0] DEC_MAX     = DIGIT_W'(9);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);
    localparam logic [CHAR_W-1:0]  DEC_COUNT   = CHAR_W'(10);

    typedef struct packed {
        logic start;
        logic div_step;
        logic write_digit;
        logic rd_en;
        logic load_out;
        logic idx_dec;
    } itrd_cmd_t;

    typedef struct packed {
        logic last_bit;
        logic q_zero;
        logic cnt_full;
        logic idx_zero;
        logic out_free;
    } itrd_sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d7;
        d7 = CHAR_W'(d);
        if (d <= DEC_MAX) begin
            return d7 + ASCII_ZERO;
        end
        return d7 - DEC_COUNT + ASCII_A;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/itrd_ctrl.sv -----
// Sequencer for the radix converter: division passes, digit writes and emission.
`default_nettype none
module itrd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire itrd_pkg::itrd_sts_t sts,
    output itrd_pkg::itrd_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.last_bit) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_digit = 1'b1;
                // stop once the quotient runs out or the store is full
                if (sts.q_zero || sts.cnt_full) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_dec = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV))
        else $error("accepted transfer did not start a division");
    a_read_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_LOAD))
        else $error("store read not followed by output load");
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && sts.idx_zero) |=> (state_reg == ST_IDLE))
        else $error("final digit did not end the run");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/itrd_dpath.sv -----
// Datapath for the radix converter: radix register, bit-serial divider, digit store, output register.
`default_nettype none
module itrd_dpath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [itrd_pkg::VALUE_W-1:0]   s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [itrd_pkg::CHAR_W-1:0]         m_digit_char,
    output logic                                m_last_digit,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [itrd_pkg::RADIX_W-1:0]   cfg_data,
    input  wire itrd_pkg::itrd_cmd_t            cmd,
    output itrd_pkg::itrd_sts_t                 sts
);

    logic [itrd_pkg::RADIX_W-1:0]    radix_reg;
    logic [itrd_pkg::RADIX_W-1:0]    radix_next;
    logic [itrd_pkg::VALUE_BITS-1:0] q_reg;
    logic [itrd_pkg::VALUE_BITS-1:0] q_next;
    logic [itrd_pkg::DIGIT_W-1:0]    rem_reg;
    logic [itrd_pkg::DIGIT_W-1:0]    rem_next;
    logic [itrd_pkg::BIT_W-1:0]      bit_reg;
    logic [itrd_pkg::BIT_W-1:0]      bit_next;
    logic [itrd_pkg::CNT_W-1:0]      cnt_reg;
    logic [itrd_pkg::CNT_W-1:0]      cnt_next;
    logic [itrd_pkg::IDX_W-1:0]      idx_reg;
    logic [itrd_pkg::IDX_W-1:0]      idx_next;
    logic [itrd_pkg::DIGIT_W-1:0]    rd_data_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [itrd_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;

    logic [itrd_pkg::DIGIT_W-1:0]    digit_mem [itrd_pkg::VALUE_BITS];

    logic [itrd_pkg::DIGIT_W:0]      shifted;
    logic                            ge;

    assign cfg_ready = 1'b1;

    // saturate the radix into range on write
    always_comb begin
        radix_next = radix_reg;
        if (cfg_valid) begin
            priority if (cfg_data < itrd_pkg::RADIX_MIN) begin
                radix_next = itrd_pkg::RADIX_MIN;
            end else if (cfg_data > itrd_pkg::RADIX_MAX) begin
                radix_next = itrd_pkg::RADIX_MAX;
            end else begin
                radix_next = cfg_data;
            end
        end
    end

    // one restoring division step: bring down the next quotient bit
    assign shifted = {rem_reg, q_reg[itrd_pkg::VALUE_BITS-1]};
    assign ge      = shifted >= {1'b0, radix_reg};

    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.start) begin
            q_next   = s_value[itrd_pkg::VALUE_BITS-1:0];
            rem_next = '0;
            bit_next = '0;
            cnt_next = '0;
        end
        if (cmd.div_step) begin
            q_next   = {q_reg[itrd_pkg::VALUE_BITS-2:0], ge};
            rem_next = ge ? itrd_pkg::DIGIT_W'(shifted - {1'b0, radix_reg})
                          : shifted[itrd_pkg::DIGIT_W-1:0];
            bit_next = bit_reg + itrd_pkg::BIT_W'(1);
        end
        if (cmd.write_digit) begin
            rem_next = '0;
            bit_next = '0;
            cnt_next = cnt_reg + itrd_pkg::CNT_W'(1);
            idx_next = cnt_reg[itrd_pkg::IDX_W-1:0];
        end
        if (cmd.idx_dec) begin
            idx_next = idx_reg - itrd_pkg::IDX_W'(1);
        end
    end

    // hold a finished digit until transfer; drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg   <= itrd_pkg::RADIX_RESET;
            q_reg       <= '0;
            rem_reg     <= '0;
            bit_reg     <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            radix_reg   <= radix_next;
            q_reg       <= q_next;
            rem_reg     <= rem_next;
            bit_reg     <= bit_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_digit) begin
            digit_mem[cnt_reg[itrd_pkg::IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= digit_mem[idx_reg];
        end
        if (cmd.load_out) begin
            char_reg <= itrd_pkg::digit_to_ascii(rd_data_reg);
            last_reg <= (idx_reg == '0);
        end
    end

    assign sts.last_bit = (bit_reg == itrd_pkg::BIT_W'(itrd_pkg::VALUE_BITS - 1));
    assign sts.q_zero   = (q_reg == '0);
    assign sts.cnt_full = (cnt_reg == itrd_pkg::CNT_W'(itrd_pkg::VALUE_BITS - 1));
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

`ifndef ASSERT_OFF
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < radix_reg)
        else $error("partial remainder not below radix");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= itrd_pkg::CNT_W'(itrd_pkg::VALUE_BITS))
        else $error("digit count beyond store depth");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten before transfer");
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (radix_reg >= itrd_pkg::RADIX_MIN) && (radix_reg <= itrd_pkg::RADIX_MAX))
        else $error("radix register out of range");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits.sv -----
// Flow: accept an input, then for each digit run the one-bit-per-cycle divider (a step
// for each of the 31 bits, then a store write); then for each digit read the store and load
// the output register, waiting while it holds an untaken digit; at most 31 digits (binary).
// One item at a time; the next is taken once the final digit sits in the output register.
// Reset (aresetn, synchronous, active low) sets the radix to 16 and clears control state;
// the digit store is not cleared.
`default_nettype none
module integer_to_radix_digits (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [itrd_pkg::VALUE_W-1:0]  s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [itrd_pkg::CHAR_W-1:0]        m_digit_char,
    output logic                               m_last_digit,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [itrd_pkg::RADIX_W-1:0]  cfg_data
);

    itrd_pkg::itrd_cmd_t cmd;
    itrd_pkg::itrd_sts_t sts;

    itrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itrd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
`default_nettype wire

// ----- bench/radix_digit_checker.sv -----
// Checker for the radix converter: predicts the digit stream of each value and compares it.
module radix_digit_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [itrd_pkg::VALUE_W-1:0]  s_value,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [itrd_pkg::CHAR_W-1:0]   m_digit_char,
    input  wire logic                          m_last_digit,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [itrd_pkg::RADIX_W-1:0]  cfg_data,
    output int                                 mismatch_count,
    output int                                 digits_pending,
    output int                                 digits_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [itrd_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    digit_t                       expected_digits[$];
    logic [itrd_pkg::RADIX_W-1:0] radix_setting = itrd_pkg::RADIX_RESET;
    int                           errors = 0;
    int                           checked = 0;

    // Divide down by the saturated radix, then queue the digits most significant first.
    task automatic queue_digits(input logic [itrd_pkg::VALUE_W-1:0] value);
        logic [itrd_pkg::RADIX_W-1:0] radix;
        logic [itrd_pkg::DIGIT_W-1:0] remainders[$];
        logic [itrd_pkg::VALUE_W-1:0] quotient;
        digit_t                       d;
        radix = (radix_setting < itrd_pkg::RADIX_MIN) ? itrd_pkg::RADIX_MIN :
                (radix_setting > itrd_pkg::RADIX_MAX) ? itrd_pkg::RADIX_MAX : radix_setting;
        // keep only the low VALUE_BITS bits of the input
        quotient = value &
                   itrd_pkg::VALUE_W'((64'd1 << itrd_pkg::VALUE_BITS) - 64'd1);
        if (quotient == '0) begin
            remainders.push_back('0);
        end
        while (quotient != '0) begin
            remainders.push_front(itrd_pkg::DIGIT_W'(quotient %
                                                     itrd_pkg::VALUE_W'(radix)));
            quotient = quotient / itrd_pkg::VALUE_W'(radix);
        end
        foreach (remainders[i]) begin
            if (remainders[i] <= itrd_pkg::DEC_MAX) begin
                d.ch = itrd_pkg::ASCII_ZERO + itrd_pkg::CHAR_W'(remainders[i]);
            end else begin
                d.ch = itrd_pkg::ASCII_A +
                       (itrd_pkg::CHAR_W'(remainders[i]) - itrd_pkg::DEC_COUNT);
            end
            d.last = (i == remainders.size() - 1);
            expected_digits.push_back(d);
        end
    endtask

    always @(posedge aclk) begin
        digit_t want;
        if (!aresetn) begin
            radix_setting = itrd_pkg::RADIX_RESET;
            expected_digits.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                radix_setting = cfg_data;
            end
            // Retire the oldest expectation before queuing digits of a new value.
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected digit transfer, expected none, got char %0d last %0b",
                             $time, m_digit_char, m_last_digit);
                end else begin
                    want = expected_digits.pop_front();
                    checked++;
                    if (m_digit_char !== want.ch) begin
                        errors++;
                        $display("%0t: digit_char mismatch, expected %0d '%c', got %0d",
                                 $time, want.ch, want.ch, m_digit_char);
                    end
                    if (m_last_digit !== want.last) begin
                        errors++;
                        $display("%0t: last_digit mismatch, expected %0b, got %0b",
                                 $time, want.last, m_last_digit);
                    end
                end
            end
            if (s_valid && s_ready) begin
                queue_digits(s_value);
            end
        end
        mismatch_count <= errors;
        digits_pending <= expected_digits.size();
        digits_checked <= checked;
    end

endmodule

// ----- bench/tb_integer_to_radix_digits.sv -----
// Testbench top for the radix converter: clock, reset, stimulus and verdict.
module tb_integer_to_radix_digits;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CYCLE_LIMIT = 4_000_000;
    localparam longint VALUE_MAX  = (64'd1 << itrd_pkg::VALUE_W) - 1;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [itrd_pkg::VALUE_W-1:0]   s_value = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [itrd_pkg::CHAR_W-1:0]    m_digit_char;
    logic                           m_last_digit;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [itrd_pkg::RADIX_W-1:0]   cfg_data = '0;

    int mismatch_count;
    int digits_pending;
    int digits_checked;
    int cycle_count = 0;
    int ready_hold = 0;
    int values_sent = 0;
    int radix_writes = 0;
    int eff_radix = 16;
    bit quiet = 1'b0;
    logic [itrd_pkg::RADIX_W-1:0] phase_radix[8];

    integer_to_radix_digits dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    radix_digit_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_char   (m_digit_char),
        .m_last_digit   (m_last_digit),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .digits_pending (digits_pending),
        .digits_checked (digits_checked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d digits still expected",
                     $time, CYCLE_LIMIT, digits_pending);
            $display("tb_integer_to_radix_digits: FAIL");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one; none at all while quiet.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    function automatic logic [itrd_pkg::VALUE_W-1:0] random_value(input int radix);
        logic [itrd_pkg::VALUE_W-1:0] v;
        longint                       p;
        int                           steps;
        v = itrd_pkg::VALUE_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5: v = v >> $urandom_range(1, itrd_pkg::VALUE_W - 1);
            6, 7: begin
                // Land on or next to a power of the radix to exercise digit-count edges.
                p = 1;
                steps = $urandom_range(1, itrd_pkg::VALUE_W);
                while (steps > 0 && p * radix <= VALUE_MAX) begin
                    p = p * radix;
                    steps--;
                end
                case ($urandom_range(0, 2))
                    0: p = p - 1;
                    1: p = p + 1;
                    default: ;
                endcase
                v = itrd_pkg::VALUE_W'(p);
            end
            8: v = itrd_pkg::VALUE_W'($urandom_range(0, 2 * radix));
            default: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
        return v;
    endfunction

    // Hold valid across back-to-back transfers; drop it only for a gap.
    task automatic send_value(input logic [itrd_pkg::VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        values_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (digits_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_radix(input logic [itrd_pkg::RADIX_W-1:0] r);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        eff_radix = int'((r < itrd_pkg::RADIX_MIN) ? itrd_pkg::RADIX_MIN :
                         (r > itrd_pkg::RADIX_MAX) ? itrd_pkg::RADIX_MAX : r);
        radix_writes++;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset radix is sixteen.
        send_value('0);
        send_value(itrd_pkg::VALUE_W'(1));
        send_value(itrd_pkg::VALUE_W'(15));
        send_value(itrd_pkg::VALUE_W'(16));
        send_value(itrd_pkg::VALUE_W'(255));
        send_value('1);
        send_value(itrd_pkg::VALUE_W'(32'h4000_0000));
        send_value(itrd_pkg::VALUE_W'(32'h2AAA_AAAA));
        send_value(itrd_pkg::VALUE_W'(32'h5555_5555));

        set_radix(itrd_pkg::RADIX_MAX);
        send_value(itrd_pkg::VALUE_W'(35));
        send_value(itrd_pkg::VALUE_W'(36));
        send_value('1);
        send_value('0);

        // Radix zero saturates to binary: all-ones gives the longest run.
        set_radix(itrd_pkg::RADIX_W'(0));
        send_value('1);
        send_value(itrd_pkg::VALUE_W'(1));
        send_value('0);

        set_radix('1);
        send_value(itrd_pkg::VALUE_W'(1295));
        send_value(itrd_pkg::VALUE_W'(36));

        set_radix(itrd_pkg::RADIX_W'(1));
        send_value(itrd_pkg::VALUE_W'(2));

        set_radix(itrd_pkg::RADIX_MAX + itrd_pkg::RADIX_W'(1));
        send_value(itrd_pkg::VALUE_W'(10));

        set_radix(itrd_pkg::RADIX_W'(10));
        send_value(itrd_pkg::VALUE_W'(9));
        send_value(itrd_pkg::VALUE_W'(10));
        send_value('1);

        phase_radix = '{itrd_pkg::RADIX_MIN, itrd_pkg::RADIX_MAX, itrd_pkg::RADIX_W'(10),
                        itrd_pkg::RADIX_W'(7), '1, itrd_pkg::RADIX_W'(1),
                        itrd_pkg::RADIX_W'(0), itrd_pkg::RADIX_W'(0)};
        phase_radix[6] = itrd_pkg::RADIX_W'($urandom_range(0, 63));
        phase_radix[7] = itrd_pkg::RADIX_W'($urandom_range(3, 35));

        for (int ph = 0; ph < 8; ph++) begin
            set_radix(phase_radix[ph]);
            for (int n = 0; n < 57; n++) begin
                quiet = (n < 8);
                send_value(random_value(eff_radix));
            end
        end
        quiet = 1'b0;

        wait_idle();
        repeat (40) @(posedge aclk);

        $display("Converted %0d values under %0d radix writes, saturating ones included;",
                 values_sent, radix_writes);
        $display("compared %0d digits with stalls on both channels.", digits_checked);
        if (mismatch_count == 0 && digits_pending == 0) begin
            $display("tb_integer_to_radix_digits: PASS");
        end else begin
            $display("tb_integer_to_radix_digits: FAIL");
        end
        $finish;
    end

endmodule
